// File: src/m68k_effective_address_unit_assert.svh
// ---------------------------------------------------------------------------
// m68k effective address unit - assertion macros
// Concurrent checks for simulation; empty bodies when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef M68K_EFFECTIVE_ADDRESS_UNIT_ASSERT_SVH
`define M68K_EFFECTIVE_ADDRESS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define M68EA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m68ea: check failed");
`define M68EA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m68ea: check failed");
`else
`define M68EA_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define M68EA_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: src/m68ea_pkg.sv
// ---------------------------------------------------------------------------
// m68ea_pkg
// Shared types, codes and helpers for the 68000 effective address unit.
// ---------------------------------------------------------------------------
package m68ea_pkg;

    localparam int WORD_W   = 32;
    localparam int RF_DEPTH = 16;              // D0-D7 then A0-A7
    localparam int RF_AW    = $clog2(RF_DEPTH);

    // queue between front and back; pointers wrap naturally, so depth is a power of two
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    // s_tdata field offsets
    localparam int SD_RN  = 0;
    localparam int SD_WV  = 3;
    localparam int SD_EA  = 35;
    localparam int SD_MSK = 41;
    localparam int SD_SZ  = 53;
    localparam int SD_E1  = 55;
    localparam int SD_E2  = 71;
    localparam int SD_PC  = 87;
    localparam int SD_WC  = 119;

    localparam logic [1:0] REQ_RESOLVE = 2'd0;
    localparam logic [1:0] REQ_WR_DATA = 2'd1;
    localparam logic [1:0] REQ_WR_ADDR = 2'd2;

    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_MEM = 2'd1;
    localparam logic [1:0] KIND_IMM = 2'd2;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;

    localparam logic [2:0] MODE_EXT = 3'd7;
    localparam logic [2:0] REG_SP   = 3'd7;

    // addressing mode index, also the bit in the allowed mask
    localparam logic [3:0] EA_DN     = 4'd0;
    localparam logic [3:0] EA_AN     = 4'd1;
    localparam logic [3:0] EA_IND    = 4'd2;
    localparam logic [3:0] EA_POSTI  = 4'd3;
    localparam logic [3:0] EA_PRED   = 4'd4;
    localparam logic [3:0] EA_D16AN  = 4'd5;
    localparam logic [3:0] EA_D8ANX  = 4'd6;
    localparam logic [3:0] EA_ABSW   = 4'd7;
    localparam logic [3:0] EA_ABSL   = 4'd8;
    localparam logic [3:0] EA_D16PC  = 4'd9;
    localparam logic [3:0] EA_D8PCX  = 4'd10;
    localparam logic [3:0] EA_IMM    = 4'd11;

    typedef enum logic [2:0] {
        BK_CONST,
        BK_WRITE,
        BK_BASE,
        BK_POSTINC,
        BK_PREDEC,
        BK_BASE_IDX,
        BK_PC_IDX
    } bk_op_t;

    typedef struct packed {
        bk_op_t              op;
        logic [1:0]          kind;
        logic                ill;
        logic [1:0]          ext;
        logic [WORD_W-1:0]   imm;
        logic [RF_AW-1:0]    base_addr;
        logic [RF_AW-1:0]    idx_addr;
        logic                idx_long;
    } q_entry_t;

    function automatic logic [WORD_W-1:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [WORD_W-1:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

// File: src/m68ea_ram.sv
// ---------------------------------------------------------------------------
// m68ea_ram
// Generic RAM: one write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
module m68ea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read returns old data on a same-cycle write to the same address
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_a <= mem_reg[rd_addr_a];
            rd_data_b <= mem_reg[rd_addr_b];
        end
    end
endmodule

// File: src/m68ea_front.sv
// ---------------------------------------------------------------------------
// m68ea_front
// Accepts request transfers and classifies them into back-end operations.
// ---------------------------------------------------------------------------
module m68ea_front (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [m68ea_pkg::S_TDATA_W-1:0]     s_tdata,   // reg_number, write_value,
                                                            // ea_field, allowed_mask, op_size,
                                                            // ext_word_first, ext_word_second,
                                                            // pc_value, words_consumed
    input  logic [m68ea_pkg::S_TUSER_W-1:0]     s_tuser,   // req_type
    output logic                                push_valid,
    input  logic                                push_ready,
    output m68ea_pkg::q_entry_t                 push_data
);
    import m68ea_pkg::*;

    logic [2:0]        rn;
    logic [31:0]       wv;
    logic [2:0]        mode;
    logic [2:0]        rsel;
    logic [11:0]       mask;
    logic [1:0]        op_size;
    logic [15:0]       e1;
    logic [15:0]       e2;
    logic [31:0]       pc;
    logic [2:0]        wc;
    logic [3:0]        mode_idx;
    logic              mode_ok;
    logic [2:0]        step;
    logic [WORD_W-1:0] pc_base;
    q_entry_t          ent;

    assign rn      = s_tdata[SD_RN +: 3];
    assign wv      = s_tdata[SD_WV +: 32];
    assign mode    = s_tdata[SD_EA + 3 +: 3];
    assign rsel    = s_tdata[SD_EA +: 3];
    assign mask    = s_tdata[SD_MSK +: 12];
    assign op_size = s_tdata[SD_SZ +: 2];
    assign e1      = s_tdata[SD_E1 +: 16];
    assign e2      = s_tdata[SD_E2 +: 16];
    assign pc      = s_tdata[SD_PC +: 32];
    assign wc      = s_tdata[SD_WC +: 3];

    assign mode_idx = (mode == MODE_EXT) ? (4'd7 + {1'b0, rsel}) : {1'b0, mode};
    assign mode_ok  = (mode_idx <= EA_IMM) ? mask[mode_idx] : 1'b0;

    // A7 stays word aligned on byte steps
    always_comb begin
        case (op_size)
            SZ_BYTE: step = (rsel == REG_SP) ? 3'd2 : 3'd1;
            SZ_WORD: step = 3'd2;
            default: step = 3'd4;
        endcase
    end

    assign pc_base = pc + {28'd0, wc, 1'b0};

    always_comb begin
        ent           = '0;
        ent.op        = BK_CONST;
        ent.kind      = KIND_REG;
        ent.base_addr = {1'b1, rsel};
        ent.idx_addr  = {e1[15], e1[14:12]};
        ent.idx_long  = e1[11];
        case (s_tuser)
            REQ_WR_DATA: begin
                ent.op        = BK_WRITE;
                ent.base_addr = {1'b0, rn};
                ent.imm       = wv;
            end
            REQ_WR_ADDR: begin
                ent.op        = BK_WRITE;
                ent.base_addr = {1'b1, rn};
                ent.imm       = wv;
            end
            REQ_RESOLVE: begin
                if (!mode_ok) begin
                    ent.ill = 1'b1;
                end else begin
                    case (mode_idx)
                        EA_DN: ent.imm = {29'd0, rsel};
                        EA_AN: ent.imm = {28'd0, 1'b1, rsel};
                        EA_IND: begin
                            ent.op   = BK_BASE;
                            ent.kind = KIND_MEM;
                        end
                        EA_POSTI: begin
                            ent.op   = BK_POSTINC;
                            ent.kind = KIND_MEM;
                            ent.imm  = {29'd0, step};
                        end
                        EA_PRED: begin
                            ent.op   = BK_PREDEC;
                            ent.kind = KIND_MEM;
                            ent.imm  = 32'd0 - {29'd0, step};
                        end
                        EA_D16AN: begin
                            ent.op   = BK_BASE;
                            ent.kind = KIND_MEM;
                            ent.ext  = 2'd1;
                            ent.imm  = sx16(e1);
                        end
                        EA_D8ANX: begin
                            ent.op   = BK_BASE_IDX;
                            ent.kind = KIND_MEM;
                            ent.ext  = 2'd1;
                            ent.imm  = sx8(e1[7:0]);
                        end
                        EA_ABSW: begin
                            ent.kind = KIND_MEM;
                            ent.ext  = 2'd1;
                            ent.imm  = sx16(e1);
                        end
                        EA_ABSL: begin
                            ent.kind = KIND_MEM;
                            ent.ext  = 2'd2;
                            ent.imm  = {e1, e2};
                        end
                        EA_D16PC: begin
                            ent.kind = KIND_MEM;
                            ent.ext  = 2'd1;
                            ent.imm  = pc_base + sx16(e1);
                        end
                        EA_D8PCX: begin
                            ent.op   = BK_PC_IDX;
                            ent.kind = KIND_MEM;
                            ent.ext  = 2'd1;
                            ent.imm  = pc_base + sx8(e1[7:0]);
                        end
                        EA_IMM: begin
                            ent.kind = KIND_IMM;
                            case (op_size)
                                SZ_BYTE: begin
                                    ent.ext = 2'd1;
                                    ent.imm = {24'd0, e1[7:0]};
                                end
                                SZ_WORD: begin
                                    ent.ext = 2'd1;
                                    ent.imm = {16'd0, e1};
                                end
                                default: begin
                                    ent.ext = 2'd2;
                                    ent.imm = {e1, e2};
                                end
                            endcase
                        end
                        default: ent.ill = 1'b1;
                    endcase
                end
            end
            default: ent.op = BK_CONST;   // unknown request: all-zero result
        endcase
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;
    assign push_data  = ent;
endmodule

// File: src/m68ea_queue.sv
// ---------------------------------------------------------------------------
// m68ea_queue
// Short FIFO of classified operations between front and back.
// ---------------------------------------------------------------------------
module m68ea_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  m68ea_pkg::q_entry_t  push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output m68ea_pkg::q_entry_t  pop_data
);
    import m68ea_pkg::*;

    q_entry_t           ent_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic               push;
    logic               pop;

    assign push_ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = ent_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// File: src/m68ea_back.sv
// ---------------------------------------------------------------------------
// m68ea_back
// Register file read, address arithmetic, write-back and result register.
// ---------------------------------------------------------------------------
`include "m68k_effective_address_unit_assert.svh"

module m68ea_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  m68ea_pkg::q_entry_t              q_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [m68ea_pkg::M_TDATA_W-1:0]  m_tdata,   // ea_result, ext_words_used
    output logic [m68ea_pkg::M_TUSER_W-1:0]  m_tuser    // ea_kind, illegal_mode
);
    import m68ea_pkg::*;

    // operand stage
    logic                b_valid_reg;
    q_entry_t            b_ent_reg;
    logic                b_ready;
    logic                b_fire;

    // register file: valid bits give the reset value of zero
    logic [RF_DEPTH-1:0] rf_vld_reg;
    logic                vld_a_reg;
    logic                vld_b_reg;
    logic [WORD_W-1:0]   rd_a;
    logic [WORD_W-1:0]   rd_b;
    logic                ram_we;
    logic [RF_AW-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;

    // bypass of the write that coincided with this item's read
    logic                fwd_valid_reg;
    logic [RF_AW-1:0]    fwd_addr_reg;
    logic [WORD_W-1:0]   fwd_data_reg;

    logic [WORD_W-1:0]   a_val;
    logic [WORD_W-1:0]   x_val;
    logic [WORD_W-1:0]   idx;
    logic [WORD_W-1:0]   sum_a;
    logic [WORD_W-1:0]   res;

    logic                m_tvalid_reg;
    logic [WORD_W-1:0]   m_result_reg;
    logic [1:0]          m_ext_reg;
    logic [1:0]          m_kind_reg;
    logic                m_ill_reg;

    assign b_fire  = b_valid_reg && (!m_tvalid_reg || m_tready);
    assign b_ready = !b_valid_reg || b_fire;
    assign q_pop   = q_valid && b_ready;

    m68ea_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .clk       (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_en     (q_pop),
        .rd_addr_a (q_data.base_addr),
        .rd_addr_b (q_data.idx_addr),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == b_ent_reg.base_addr)) begin
            a_val = fwd_data_reg;
        end else begin
            a_val = vld_a_reg ? rd_a : '0;
        end
        if (fwd_valid_reg && (fwd_addr_reg == b_ent_reg.idx_addr)) begin
            x_val = fwd_data_reg;
        end else begin
            x_val = vld_b_reg ? rd_b : '0;
        end
    end

    assign idx   = b_ent_reg.idx_long ? x_val : sx16(x_val[15:0]);
    assign sum_a = a_val + b_ent_reg.imm;

    always_comb begin
        res       = b_ent_reg.imm;
        ram_we    = 1'b0;
        ram_waddr = b_ent_reg.base_addr;
        ram_wdata = sum_a;
        case (b_ent_reg.op)
            BK_CONST: res = b_ent_reg.imm;
            BK_WRITE: begin
                res       = '0;
                ram_we    = b_fire;
                ram_wdata = b_ent_reg.imm;
            end
            BK_BASE:  res = sum_a;
            BK_POSTINC: begin
                res    = a_val;
                ram_we = b_fire;
            end
            BK_PREDEC: begin
                res    = sum_a;
                ram_we = b_fire;
            end
            BK_BASE_IDX: res = sum_a + idx;
            BK_PC_IDX:   res = b_ent_reg.imm + idx;
            default:     res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            rf_vld_reg    <= '0;
        end else begin
            if (b_ready) begin
                b_valid_reg <= q_valid;
            end
            if (b_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (q_pop) begin
                fwd_valid_reg <= ram_we;
            end
            if (ram_we) begin
                rf_vld_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b_ent_reg    <= q_data;
            vld_a_reg    <= rf_vld_reg[q_data.base_addr];
            vld_b_reg    <= rf_vld_reg[q_data.idx_addr];
            fwd_addr_reg <= ram_waddr;
            fwd_data_reg <= ram_wdata;
        end
        if (b_fire) begin
            m_result_reg <= res;
            m_ext_reg    <= b_ent_reg.ext;
            m_kind_reg   <= b_ent_reg.kind;
            m_ill_reg    <= b_ent_reg.ill;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - 2){1'b0}}, m_ext_reg, m_result_reg};
    assign m_tuser  = {m_ill_reg, m_kind_reg};

    `M68EA_ASSERT_IMP(a_ill_zero, aclk, aresetn, m_tvalid_reg && m_ill_reg, (m_result_reg == '0) && (m_ext_reg == 2'd0) && (m_kind_reg == KIND_REG))
    `M68EA_ASSERT_IMP(a_no_wr_stall, aclk, aresetn, m_tvalid_reg && !m_tready, !ram_we)
    `M68EA_ASSERT_NXT(a_fwd_set, aclk, aresetn, q_pop && ram_we, fwd_valid_reg)
    `M68EA_ASSERT_IMP(a_ext_range, aclk, aresetn, m_tvalid_reg, m_ext_reg != 2'd3)
endmodule

// File: src/m68k_effective_address_unit.sv
// ---------------------------------------------------------------------------
// m68k_effective_address_unit
// 68000 effective address resolution with the D0-D7 / A0-A7 register file.
// ---------------------------------------------------------------------------
// One request transfer is taken per clock and one result transfer leaves per
// clock in steady flow. The queue slot is written on the edge that accepts a
// request; the register file read then loads the operand stage, and the result
// register is loaded from it. The rate is set by the register file, which is
// read and written back once per item, with the write of one item bypassed
// into the operands of the next. Register write requests and the (An)+ / -(An)
// updates take effect in request order. A two-entry queue separates decode
// from execution, so s_tready drops only when the queue is full and the result
// side has stalled.
// ---------------------------------------------------------------------------
module m68k_effective_address_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [m68ea_pkg::S_TDATA_W-1:0]  s_tdata,   // reg_number, write_value,
                                                         // ea_field, allowed_mask, op_size,
                                                         // ext_word_first, ext_word_second,
                                                         // pc_value, words_consumed, zero pad
    input  logic [m68ea_pkg::S_TUSER_W-1:0]  s_tuser,   // req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [m68ea_pkg::M_TDATA_W-1:0]  m_tdata,   // ea_result, ext_words_used, zero pad
    output logic [m68ea_pkg::M_TUSER_W-1:0]  m_tuser    // ea_kind, illegal_mode
);
    import m68ea_pkg::*;

    logic     push_valid;
    logic     push_ready;
    q_entry_t push_data;
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_data;

    m68ea_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    m68ea_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    m68ea_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule

// File: test/m68k_ea_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m68k_ea_checker
// Watches both stream channels of the effective address unit. Every request
// transfer is resolved against a private copy of D0-D7 / A0-A7 and the
// outcome is queued; every result transfer is compared field by field with
// the oldest queued outcome. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module m68k_ea_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [m68ea_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [m68ea_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [m68ea_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [m68ea_pkg::M_TUSER_W-1:0]  m_tuser,
    output int                               error_count,
    output int                               outstanding
);
    import m68ea_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        illegal;
        logic [1:0]  ext_used;
    } ea_outcome_t;

    logic [31:0]  data_reg [8];
    logic [31:0]  addr_reg [8];
    ea_outcome_t  expected_ea_q [$];

    function automatic logic [31:0] widen_word(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] widen_byte(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic logic [31:0] step_size(input logic [1:0] size, input logic [2:0] rg);
        if (size == SZ_BYTE) begin
            return (rg == REG_SP) ? 32'd2 : 32'd1;   // keep the stack word aligned
        end
        if (size == SZ_WORD) begin
            return 32'd2;
        end
        return 32'd4;
    endfunction

    // brief extension word: signed 8-bit displacement plus Dn/An index, .W or .L
    function automatic logic [31:0] brief_offset(input logic [15:0] ext);
        logic [31:0] idx;
        idx = ext[15] ? addr_reg[ext[14:12]] : data_reg[ext[14:12]];
        if (!ext[11]) begin
            idx = widen_word(idx[15:0]);
        end
        return widen_byte(ext[7:0]) + idx;
    endfunction

    task automatic resolve_request(input logic [S_TUSER_W-1:0] req,
                                   input logic [S_TDATA_W-1:0] td,
                                   output ea_outcome_t res);
        logic [2:0]  rn, mode, rg, wc;
        logic [31:0] wv, pc, pc_base;
        logic [5:0]  ea;
        logic [11:0] mask;
        logic [1:0]  size;
        logic [15:0] e1, e2;
        logic [3:0]  sel;
        rn   = td[SD_RN  +: 3];
        wv   = td[SD_WV  +: 32];
        ea   = td[SD_EA  +: 6];
        mask = td[SD_MSK +: 12];
        size = td[SD_SZ  +: 2];
        e1   = td[SD_E1  +: 16];
        e2   = td[SD_E2  +: 16];
        pc   = td[SD_PC  +: 32];
        wc   = td[SD_WC  +: 3];
        mode = ea[5:3];
        rg   = ea[2:0];
        pc_base = pc + {28'd0, wc, 1'b0};
        res = '0;
        if (req == REQ_WR_DATA) begin
            data_reg[rn] = wv;
        end else if (req == REQ_WR_ADDR) begin
            addr_reg[rn] = wv;
        end else if (req == REQ_RESOLVE) begin
            sel = (mode == MODE_EXT) ? EA_ABSW + {1'b0, rg} : {1'b0, mode};
            if (sel > EA_IMM || !mask[sel]) begin
                res.illegal = 1'b1;
            end else begin
                res.kind = KIND_MEM;
                case (sel)
                    EA_DN: begin
                        res.kind  = KIND_REG;
                        res.value = {29'd0, rg};
                    end
                    EA_AN: begin
                        res.kind  = KIND_REG;
                        res.value = 32'd8 + {29'd0, rg};
                    end
                    EA_IND:   res.value = addr_reg[rg];
                    EA_POSTI: begin
                        res.value    = addr_reg[rg];
                        addr_reg[rg] = addr_reg[rg] + step_size(size, rg);
                    end
                    EA_PRED: begin
                        addr_reg[rg] = addr_reg[rg] - step_size(size, rg);
                        res.value    = addr_reg[rg];
                    end
                    EA_D16AN: begin
                        res.ext_used = 2'd1;
                        res.value    = addr_reg[rg] + widen_word(e1);
                    end
                    EA_D8ANX: begin
                        res.ext_used = 2'd1;
                        res.value    = addr_reg[rg] + brief_offset(e1);
                    end
                    EA_ABSW: begin
                        res.ext_used = 2'd1;
                        res.value    = widen_word(e1);
                    end
                    EA_ABSL: begin
                        res.ext_used = 2'd2;
                        res.value    = {e1, e2};
                    end
                    EA_D16PC: begin
                        res.ext_used = 2'd1;
                        res.value    = pc_base + widen_word(e1);
                    end
                    EA_D8PCX: begin
                        res.ext_used = 2'd1;
                        res.value    = pc_base + brief_offset(e1);
                    end
                    default: begin
                        res.kind = KIND_IMM;
                        if (size >= 2'd2) begin
                            res.ext_used = 2'd2;
                            res.value    = {e1, e2};
                        end else if (size == SZ_WORD) begin
                            res.ext_used = 2'd1;
                            res.value    = {16'd0, e1};
                        end else begin
                            res.ext_used = 2'd1;
                            res.value    = {24'd0, e1[7:0]};
                        end
                    end
                endcase
            end
        end
    endtask

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        ea_outcome_t want, seen, pred;
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                data_reg[i] = '0;
                addr_reg[i] = '0;
            end
            expected_ea_q.delete();
            error_count = 0;
            outstanding <= 0;
        end else begin
            // result side first: a result can never belong to this edge's request
            if (m_tvalid && m_tready) begin
                seen.kind     = m_tuser[1:0];
                seen.illegal  = m_tuser[2];
                seen.value    = m_tdata[31:0];
                seen.ext_used = m_tdata[33:32];
                if (expected_ea_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual %h",
                             $time, seen);
                    error_count++;
                end else begin
                    want = expected_ea_q.pop_front();
                    error_count += field_mismatch("ea_kind", 32'(want.kind),
                                                  32'(seen.kind));
                    error_count += field_mismatch("ea_result", want.value, seen.value);
                    error_count += field_mismatch("illegal_mode", 32'(want.illegal),
                                                  32'(seen.illegal));
                    error_count += field_mismatch("ext_words_used", 32'(want.ext_used),
                                                  32'(seen.ext_used));
                end
            end
            if (s_tvalid && s_tready) begin
                resolve_request(s_tuser, s_tdata, pred);
                expected_ea_q.push_back(pred);
            end
            outstanding <= expected_ea_q.size();
        end
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the effective address unit with a directed set of register writes
// and every addressing mode, then bursts of random requests, while the result
// side stalls on its own pattern including one long hold-off. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import m68ea_pkg::*;

    localparam logic [1:0]  REQ_IGNORED = 2'd3;
    localparam logic [11:0] ALL_MODES   = 12'hFFF;
    localparam int          ITEM_COUNT  = 1750;
    localparam int          HOLD_CYCLES = 300;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    int error_count;
    int outstanding;
    int sent_count  = 0;
    int rx_cycle    = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    always #5 aclk = ~aclk;

    m68k_effective_address_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    m68k_ea_checker ea_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    function automatic logic [S_TDATA_W-1:0] pack_request(
        input logic [2:0] rn, input logic [31:0] wv, input logic [5:0] ea,
        input logic [11:0] mask, input logic [1:0] size, input logic [15:0] e1,
        input logic [15:0] e2, input logic [31:0] pc, input logic [2:0] wc);
        logic [S_TDATA_W-1:0] td;
        td = '0;
        td[SD_RN  +: 3]  = rn;
        td[SD_WV  +: 32] = wv;
        td[SD_EA  +: 6]  = ea;
        td[SD_MSK +: 12] = mask;
        td[SD_SZ  +: 2]  = size;
        td[SD_E1  +: 16] = e1;
        td[SD_E2  +: 16] = e2;
        td[SD_PC  +: 32] = pc;
        td[SD_WC  +: 3]  = wc;
        return td;
    endfunction

    // returns at the edge where the transfer happened; valid is left high
    task automatic send_item(input logic [1:0] req, input logic [S_TDATA_W-1:0] td);
        s_tuser  <= req;
        s_tdata  <= td;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic send_write(input logic [1:0] req, input logic [2:0] rn,
                              input logic [31:0] value);
        send_item(req, pack_request(rn, value, '0, '0, '0, '0, '0, '0, '0));
    endtask

    task automatic send_resolve(input logic [5:0] ea, input logic [11:0] mask,
                                input logic [1:0] size, input logic [15:0] e1,
                                input logic [15:0] e2, input logic [31:0] pc,
                                input logic [2:0] wc);
        send_item(REQ_RESOLVE, pack_request('0, '0, ea, mask, size, e1, e2, pc, wc));
    endtask

    // result side: phased stall pattern, plus one long hold-off mid-run
    always @(posedge aclk) begin
        rx_cycle++;
        if (!hold_done && sent_count >= 900) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 512) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 9) < 3);
                default: m_tready <= rx_cycle[0];
            endcase
        end
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [S_TDATA_W-1:0] td;
        logic [1:0]           req;
        logic [11:0]          mask;
        logic [31:0]          value;
        int                   burst;
        int                   gap;
        int                   pick;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: register extremes, every mode, reserved and disallowed cases
        send_write(REQ_WR_DATA, 3'd0, 32'hFFFF_FFFF);
        send_write(REQ_WR_DATA, 3'd7, 32'h7FFF_8001);
        send_write(REQ_WR_ADDR, 3'd0, 32'h0000_1000);
        send_write(REQ_WR_ADDR, 3'd3, 32'h8000_0000);
        send_write(REQ_WR_ADDR, REG_SP, 32'hFFFF_FFFE);
        send_resolve({3'd0, 3'd5}, ALL_MODES, SZ_WORD, '0, '0, '0, '0);
        send_resolve({3'd1, 3'd7}, ALL_MODES, SZ_WORD, '0, '0, '0, '0);
        send_resolve({3'd2, 3'd0}, ALL_MODES, SZ_WORD, '0, '0, '0, '0);
        send_resolve({3'd3, REG_SP}, ALL_MODES, SZ_BYTE, '0, '0, '0, '0);  // SP steps by 2
        send_resolve({3'd3, 3'd3}, ALL_MODES, SZ_BYTE, '0, '0, '0, '0);
        send_resolve({3'd4, REG_SP}, ALL_MODES, SZ_BYTE, '0, '0, '0, '0);
        send_resolve({3'd4, 3'd0}, ALL_MODES, 2'd3, '0, '0, '0, '0);       // size 3 as long
        send_resolve({3'd5, 3'd0}, ALL_MODES, SZ_WORD, 16'h8000, '0, '0, '0);
        send_resolve({3'd6, 3'd0}, ALL_MODES, SZ_WORD, 16'h0080, '0, '0, '0);
        send_resolve({3'd6, 3'd3}, ALL_MODES, SZ_WORD, 16'hF87F, '0, '0, '0);
        send_resolve({MODE_EXT, 3'd0}, ALL_MODES, SZ_WORD, 16'hFFFF, '0, '0, '0);
        send_resolve({MODE_EXT, 3'd1}, ALL_MODES, SZ_WORD, 16'hDEAD, 16'hBEEF, '0, '0);
        send_resolve({MODE_EXT, 3'd2}, ALL_MODES, SZ_WORD, 16'h7FFF, '0,
                     32'hFFFF_FFF0, 3'd7);
        send_resolve({MODE_EXT, 3'd3}, ALL_MODES, SZ_WORD, 16'h7001, '0, '0, '0);
        send_resolve({MODE_EXT, 3'd4}, ALL_MODES, SZ_BYTE, 16'h12AB, '0, '0, '0);
        send_resolve({MODE_EXT, 3'd4}, ALL_MODES, SZ_WORD, 16'h8001, '0, '0, '0);
        send_resolve({MODE_EXT, 3'd4}, ALL_MODES, 2'd2, 16'hDEAD, 16'hBEEF, '0, '0);
        send_resolve({MODE_EXT, 3'd5}, ALL_MODES, SZ_WORD, '0, '0, '0, '0);
        send_resolve({MODE_EXT, 3'd7}, ALL_MODES, SZ_WORD, '0, '0, '0, '0);
        send_resolve({3'd2, 3'd0}, 12'hFFB, SZ_WORD, '0, '0, '0, '0);
        send_item(REQ_IGNORED, pack_request(3'd7, 32'hFFFF_FFFF, 6'h3F, ALL_MODES, 2'd3,
                                            16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 3'd7));

        // random bursts; mostly permissive masks so the modes resolve
        burst = 0;
        for (int n = 0; n < ITEM_COUNT; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            pick  = $urandom_range(0, 99);
            mask  = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095)) : ALL_MODES;
            value = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom;
            td = pack_request(3'($urandom_range(0, 7)), value, 6'($urandom_range(0, 63)),
                              mask, 2'($urandom_range(0, 3)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              $urandom, 3'($urandom_range(0, 7)));
            if (pick < 12) begin
                req = REQ_WR_DATA;
            end else if (pick < 24) begin
                req = REQ_WR_ADDR;
            end else if (pick < 27) begin
                req = REQ_IGNORED;
            end else begin
                req = REQ_RESOLVE;
            end
            send_item(req, td);
            burst--;
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: m68k_effective_address_unit.f
+incdir+src
src/m68ea_pkg.sv
src/m68ea_ram.sv
src/m68ea_front.sv
src/m68ea_queue.sv
src/m68ea_back.sv
src/m68k_effective_address_unit.sv
test/m68k_ea_checker.sv
test/testbench.sv
